@@ design/dsmg_pkg.sv @@
// Shared types and constants for the dual-axis stepper move generator.
`timescale 1ns / 1ps
`default_nettype none
package dsmg_pkg;

  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned RAMP_W   = 10;
  localparam int unsigned TARGET_W = 16;
  localparam int unsigned POS_W    = 32;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_PERIOD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEPS    = 2'd2;

  localparam logic [PERIOD_W-1:0] NORMAL_PERIOD_RST = 16'd2000;
  localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RST   = 16'd5000;
  localparam logic [RAMP_W-1:0]   RAMP_STEPS_RST    = 10'd50;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PMUL,
    ST_PDIV,
    ST_PFIN,
    ST_LMUL,
    ST_LDIV,
    ST_LFIN,
    ST_RMUL,
    ST_RDIV,
    ST_RFIN,
    ST_TEND,
    ST_OUT
  } state_e;

endpackage
`default_nettype wire

@@ design/dsmg_cmd_if.sv @@
// Command channel: move load or step tick, valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface dsmg_cmd_if import dsmg_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic signed [TARGET_W-1:0] target_left;
  logic signed [TARGET_W-1:0] target_right;

  modport source (output valid, func, target_left, target_right, input ready);
  modport sink   (input valid, func, target_left, target_right, output ready);
endinterface
`default_nettype wire

@@ design/dsmg_res_if.sv @@
// Result channel: step pulses, directions, period and positions.
`timescale 1ns / 1ps
`default_nettype none
interface dsmg_res_if import dsmg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    step_left;
  logic                    step_right;
  logic                    dir_left;
  logic                    dir_right;
  logic [PERIOD_W-1:0]     step_period;
  logic signed [POS_W-1:0] pos_left;
  logic signed [POS_W-1:0] pos_right;
  logic                    move_done;

  modport source (output valid, step_left, step_right, dir_left, dir_right, step_period,
                  pos_left, pos_right, move_done, input ready);
  modport sink   (input valid, step_left, step_right, dir_left, dir_right, step_period,
                  pos_left, pos_right, move_done, output ready);
endinterface
`default_nettype wire

@@ design/dual_axis_stepper_move_generator.sv @@
// Dual-axis stepper move generator: linear interpolation with a linear speed ramp.
//
// cmd_i takes one transaction per item: func 0 loads a relative move (signed step
// counts per axis), func 1 is one step tick. res_o returns exactly one transaction
// per item: step pulses, direction levels, the period to wait, both position
// counters and a done flag. The cfg port writes normal_period, slow_period and
// ramp_steps at any edge with cfg_we_i high; write it only while the block is idle.
// A load or a tick with no active move goes from the idle state to ST_OUT and is
// then written into the output register. A tick of an active move runs one shared
// multiplier and one shared restoring divider (one quotient bit per cycle, quotient
// width QW = max(COUNT_BITS,16)) for the ramp period and for each axis, one
// division each; a ramp-free tick or an axis with no steps left skips its division.
// cmd_i.ready is high only while the sequencer is idle, so a new item is not
// accepted until the last one has been handed to the output register.
// A finished result sits in the output register until taken; the next item is
// accepted meanwhile and stalls only at its own hand-off.
// Reset restores the register defaults, clears positions and leaves no move active.
`timescale 1ns / 1ps
`default_nettype none
module dual_axis_stepper_move_generator import dsmg_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  dsmg_cmd_if.sink                  cmd_i,
  dsmg_res_if.source                res_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned CB = COUNT_BITS;
  localparam int unsigned QW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam int unsigned SW = QW + 1;
  localparam int unsigned CW = $clog2(QW);

  typedef logic [CB-1:0]   cnt_t;
  typedef logic [QW-1:0]   qw_t;
  typedef logic [SW-1:0]   sw_t;
  typedef logic [CW-1:0]   cw_t;

  // configuration
  logic [PERIOD_W-1:0] normal_q, slow_q;
  logic [RAMP_W-1:0]   ramp_q;

  // move state
  cnt_t                total_l_q, total_r_q, rem_l_q, rem_r_q, longest_q, tick_q;
  logic [1:0]          dir_q;
  logic [POS_W-1:0]    pos_l_q, pos_r_q;
  logic                active_q;

  // sequencer and shared datapath
  state_e              state_q, state_d;
  logic [RAMP_W-1:0]   x_q;
  logic [PERIOD_W-1:0] c_q, mag_q;
  logic                neg_q;
  qw_t                 rem_q, lo_q, div_q;
  cw_t                 cnt_q;
  logic                step_l_q, step_r_q;
  logic [PERIOD_W-1:0] period_q;
  logic                out_valid_q;

  // control decode
  logic cmd_ready, cmd_fire, out_load, div_last;

  always_comb begin
    cmd_ready = (state_q == ST_IDLE);
    out_load  = (state_q == ST_OUT) && (!out_valid_q || res_o.ready);
  end

  assign cmd_i.ready = cmd_ready;
  assign cmd_fire    = cmd_i.valid && cmd_ready;
  assign div_last    = (cnt_q == cw_t'(QW - 1));

  // load decode: magnitude of a 16-bit two's complement count, -32768 gives 32768
  logic [16:0] mag_l17, mag_r17;
  logic [31:0] mag_l32, mag_r32;
  cnt_t        new_tl, new_tr, new_m;

  always_comb begin
    mag_l17 = cmd_i.target_left[15] ? (17'h10000 - {1'b0, cmd_i.target_left})
                                    : {1'b0, cmd_i.target_left};
    mag_r17 = cmd_i.target_right[15] ? (17'h10000 - {1'b0, cmd_i.target_right})
                                     : {1'b0, cmd_i.target_right};
    mag_l32 = {15'd0, mag_l17};
    mag_r32 = {15'd0, mag_r17};
    new_tl  = mag_l32[CB-1:0];
    new_tr  = mag_r32[CB-1:0];
    new_m   = (new_tl > new_tr) ? new_tl : new_tr;
  end

  // ramp branch select for the current tick
  sw_t                 sw_tick, sw_sum, sw_x2;
  logic                br_up, br_down, ramp_sel;
  logic [RAMP_W-1:0]   x_sel;
  logic [PERIOD_W-1:0] c_sel, d_sel;
  logic [PERIOD_W:0]   diff_sel;

  always_comb begin
    sw_tick  = sw_t'(tick_q);
    sw_sum   = sw_tick + sw_t'(ramp_q);
    sw_x2    = sw_sum - sw_t'(longest_q);
    br_up    = sw_tick < sw_t'(ramp_q);
    br_down  = sw_sum >= sw_t'(longest_q);
    ramp_sel = br_up || br_down;
    x_sel    = br_up ? sw_tick[RAMP_W-1:0] : sw_x2[RAMP_W-1:0];
    c_sel    = br_up ? slow_q : normal_q;
    d_sel    = br_up ? normal_q : slow_q;
    diff_sel = {1'b0, d_sel} - {1'b0, c_sel};
  end

  // shared multiplier
  qw_t             mul_a, mul_b;
  logic [2*QW-1:0] prod;

  always_comb begin
    case (state_q)
      ST_PMUL: begin
        mul_a = qw_t'(x_q);
        mul_b = qw_t'(mag_q);
      end
      ST_LMUL: begin
        mul_a = qw_t'(tick_q);
        mul_b = qw_t'(total_l_q);
      end
      ST_RMUL: begin
        mul_a = qw_t'(tick_q);
        mul_b = qw_t'(total_r_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
  end

  // shared restoring divider step; quotient bits shift into lo_q
  logic [QW:0] div_t, div_sub;
  logic        div_ge;
  qw_t         rem_n, lo_n;

  always_comb begin
    div_t   = {rem_q, lo_q[QW-1]};
    div_sub = div_t - {1'b0, div_q};
    div_ge  = div_t >= {1'b0, div_q};
    rem_n   = div_ge ? div_sub[QW-1:0] : div_t[QW-1:0];
    lo_n    = {lo_q[QW-2:0], div_ge};
  end

  // axis decisions
  logic step_l_ok, step_r_ok;

  always_comb begin
    step_l_ok = lo_q >= qw_t'(total_l_q - rem_l_q);
    step_r_ok = lo_q >= qw_t'(total_r_q - rem_r_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_fire) begin
          if (cmd_i.func == FUNC_TICK && active_q) begin
            state_d = ramp_sel ? ST_PMUL : ST_LMUL;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_PMUL: state_d = ST_PDIV;
      ST_PDIV: if (div_last) state_d = ST_PFIN;
      ST_PFIN: state_d = ST_LMUL;
      ST_LMUL: state_d = (rem_l_q == '0) ? ST_RMUL : ST_LDIV;
      ST_LDIV: if (div_last) state_d = ST_LFIN;
      ST_LFIN: state_d = ST_RMUL;
      ST_RMUL: state_d = (rem_r_q == '0) ? ST_TEND : ST_RDIV;
      ST_RDIV: if (div_last) state_d = ST_RFIN;
      ST_RFIN: state_d = ST_TEND;
      ST_TEND: state_d = ST_OUT;
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_q <= NORMAL_PERIOD_RST;
      slow_q   <= SLOW_PERIOD_RST;
      ramp_q   <= RAMP_STEPS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_NORMAL_PERIOD: normal_q <= cfg_data_i[PERIOD_W-1:0];
        REG_SLOW_PERIOD:   slow_q   <= cfg_data_i[PERIOD_W-1:0];
        REG_RAMP_STEPS:    ramp_q   <= cfg_data_i[RAMP_W-1:0];
        default: ;
      endcase
    end
  end

  // move state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_l_q <= '0;
      total_r_q <= '0;
      rem_l_q   <= '0;
      rem_r_q   <= '0;
      longest_q <= '0;
      tick_q    <= '0;
      dir_q     <= '0;
      pos_l_q   <= '0;
      pos_r_q   <= '0;
      active_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cmd_fire && cmd_i.func == FUNC_LOAD) begin
            dir_q     <= {cmd_i.target_right[15], cmd_i.target_left[15]};
            total_l_q <= new_tl;
            total_r_q <= new_tr;
            rem_l_q   <= new_tl;
            rem_r_q   <= new_tr;
            longest_q <= new_m;
            tick_q    <= '0;
            active_q  <= (new_m != '0);
          end
        end
        ST_LFIN: begin
          if (step_l_ok) begin
            pos_l_q <= dir_q[0] ? (pos_l_q - 1'b1) : (pos_l_q + 1'b1);
            rem_l_q <= rem_l_q - 1'b1;
          end
        end
        ST_RFIN: begin
          if (step_r_ok) begin
            pos_r_q <= dir_q[1] ? (pos_r_q - 1'b1) : (pos_r_q + 1'b1);
            rem_r_q <= rem_r_q - 1'b1;
          end
        end
        ST_TEND: begin
          tick_q <= tick_q + 1'b1;
          if ((sw_tick + 1'b1) >= sw_t'(longest_q)) active_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // working registers of the shared unit
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (cmd_fire) begin
          step_l_q <= 1'b0;
          step_r_q <= 1'b0;
          period_q <= (cmd_i.func == FUNC_TICK && active_q) ? normal_q : '0;
          x_q      <= x_sel;
          c_q      <= c_sel;
          neg_q    <= diff_sel[PERIOD_W];
          mag_q    <= diff_sel[PERIOD_W] ? (~diff_sel[PERIOD_W-1:0] + 1'b1)
                                         : diff_sel[PERIOD_W-1:0];
        end
      end
      ST_PMUL: begin
        {rem_q, lo_q} <= prod;
        div_q         <= qw_t'(ramp_q);
        cnt_q         <= '0;
      end
      ST_LMUL: begin
        {rem_q, lo_q} <= prod;
        div_q         <= qw_t'(longest_q);
        cnt_q         <= '0;
      end
      ST_RMUL: begin
        {rem_q, lo_q} <= prod;
        div_q         <= qw_t'(longest_q);
        cnt_q         <= '0;
      end
      ST_PDIV, ST_LDIV, ST_RDIV: begin
        rem_q <= rem_n;
        lo_q  <= lo_n;
        cnt_q <= cnt_q + 1'b1;
      end
      ST_PFIN: begin
        // quotient of the ramp term is below 2^16, truncation toward zero via sign
        period_q <= neg_q ? (c_q - lo_q[PERIOD_W-1:0]) : (c_q + lo_q[PERIOD_W-1:0]);
      end
      ST_LFIN: if (step_l_ok) step_l_q <= 1'b1;
      ST_RFIN: if (step_r_ok) step_r_q <= 1'b1;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_o.step_left   <= step_l_q;
      res_o.step_right  <= step_r_q;
      res_o.dir_left    <= dir_q[0];
      res_o.dir_right   <= dir_q[1];
      res_o.step_period <= period_q;
      res_o.pos_left    <= pos_l_q;
      res_o.pos_right   <= pos_r_q;
      res_o.move_done   <= !active_q;
    end
  end

  assign res_o.valid = out_valid_q;

endmodule
`default_nettype wire

@@ tb/sv/dsmg_step_checker.sv @@
// Observes the move generator channels, predicts each result and compares it.
`timescale 1ns / 1ps
module dsmg_step_checker import dsmg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  dsmg_cmd_if                  cmd,
  dsmg_res_if                  res,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef struct {
    logic                step_l;
    logic                step_r;
    logic                dir_l;
    logic                dir_r;
    logic [PERIOD_W-1:0] period;
    logic [POS_W-1:0]    pos_l;
    logic [POS_W-1:0]    pos_r;
    logic                done;
  } step_outcome_t;

  step_outcome_t step_outcomes[$];

  // register copies
  logic [PERIOD_W-1:0] normal_per;
  logic [PERIOD_W-1:0] slow_per;
  logic [RAMP_W-1:0]   ramp_len;

  // move state
  logic [15:0]      total_l, total_r, left_l, left_r, longest, tick_idx;
  logic [1:0]       dirs;
  logic [POS_W-1:0] pos_l, pos_r;
  logic             active;

  int fails;
  int reported;

  // (x-a)*(d-c)/(b-a)+c, signed division truncates toward zero
  function automatic longint interp(longint x, longint a, longint b, longint c, longint d);
    if (b == a) return c;
    return (x - a) * (d - c) / (b - a) + c;
  endfunction

  function automatic logic [PERIOD_W-1:0] ramp_period(longint i, longint m);
    longint r, n, s, v;
    r = ramp_len;
    n = normal_per;
    s = slow_per;
    if (i < r) v = interp(i, 0, r, s, n);
    else if (i >= m - r) v = interp(i, m - r, m, n, s);
    else v = n;
    return v[PERIOD_W-1:0];
  endfunction

  function automatic logic axis_fires(longint i, longint total, longint remaining);
    longint m;
    m = longest;
    if (remaining == 0 || m == 0) return 1'b0;
    return (i * total) / m >= total - remaining;
  endfunction

  function automatic step_outcome_t predict_item(logic func, logic [15:0] tl, logic [15:0] tr);
    step_outcome_t o;
    longint i;
    o.step_l = 1'b0;
    o.step_r = 1'b0;
    o.period = '0;
    if (func == FUNC_LOAD) begin
      dirs     = {tr[15], tl[15]};
      total_l  = tl[15] ? 16'(-tl) : tl;
      total_r  = tr[15] ? 16'(-tr) : tr;
      left_l   = total_l;
      left_r   = total_r;
      longest  = (total_l > total_r) ? total_l : total_r;
      tick_idx = '0;
      active   = (longest != 0);
    end else if (active) begin
      i = tick_idx;
      o.period = ramp_period(i, longest);
      if (axis_fires(i, total_l, left_l)) begin
        o.step_l = 1'b1;
        pos_l    = dirs[0] ? pos_l - 1 : pos_l + 1;
        left_l   = 16'(left_l - 1);
      end
      if (axis_fires(i, total_r, left_r)) begin
        o.step_r = 1'b1;
        pos_r    = dirs[1] ? pos_r - 1 : pos_r + 1;
        left_r   = 16'(left_r - 1);
      end
      tick_idx = 16'(tick_idx + 1);
      if (i + 1 >= longint'(longest)) active = 1'b0;
    end
    o.dir_l = dirs[0];
    o.dir_r = dirs[1];
    o.pos_l = pos_l;
    o.pos_r = pos_r;
    o.done  = !active;
    return o;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fails++;
      if (reported < 10) begin
        reported++;
        $display("%t mismatch on %s: expected %h, got %h", $realtime, name, want, got);
      end
    end
  endtask

  task automatic compare_result();
    step_outcome_t want;
    if (step_outcomes.size() == 0) begin
      fails++;
      if (reported < 10) begin
        reported++;
        $display("%t result transaction with nothing outstanding", $realtime);
      end
    end else begin
      want = step_outcomes.pop_front();
      check_field("step_left", 32'(want.step_l), 32'(res.step_left));
      check_field("step_right", 32'(want.step_r), 32'(res.step_right));
      check_field("dir_left", 32'(want.dir_l), 32'(res.dir_left));
      check_field("dir_right", 32'(want.dir_r), 32'(res.dir_right));
      check_field("step_period", 32'(want.period), 32'(res.step_period));
      check_field("pos_left", want.pos_l, res.pos_left);
      check_field("pos_right", want.pos_r, res.pos_right);
      check_field("move_done", 32'(want.done), 32'(res.move_done));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_per   = NORMAL_PERIOD_RST;
      slow_per     = SLOW_PERIOD_RST;
      ramp_len     = RAMP_STEPS_RST;
      total_l      = '0;
      total_r      = '0;
      left_l       = '0;
      left_r       = '0;
      longest      = '0;
      tick_idx     = '0;
      dirs         = '0;
      pos_l        = '0;
      pos_r        = '0;
      active       = 1'b0;
      fails        = 0;
      reported     = 0;
      step_outcomes.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (res.valid && res.ready) compare_result();
      if (cmd.valid && cmd.ready)
        step_outcomes.push_back(predict_item(cmd.func, cmd.target_left, cmd.target_right));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_NORMAL_PERIOD: normal_per = cfg_data_i;
          REG_SLOW_PERIOD:   slow_per   = cfg_data_i;
          REG_RAMP_STEPS:    ramp_len   = cfg_data_i[RAMP_W-1:0];
          default: ;
        endcase
      end
      fail_count_o <= fails;
      pending_o    <= step_outcomes.size();
    end
  end

endmodule

@@ tb/sv/tb_dual_axis_stepper_move_generator.sv @@
// Top of the move generator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_dual_axis_stepper_move_generator;
  import dsmg_pkg::*;

  localparam int ITEM_GOAL  = 925;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN      = 80;

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  int fail_count;
  int pending;
  int items = 0;
  int loads = 0;
  int ticks = 0;
  int settings = 0;
  int results_taken = 0;
  int idle_cycles = 0;
  bit steady = 1'b0;

  dsmg_cmd_if cmd_if ();
  dsmg_res_if res_if ();

  dual_axis_stepper_move_generator dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cmd_i      (cmd_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  dsmg_step_checker step_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cmd          (cmd_if),
    .res          (res_if),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_draw();
    if (steady) return 0;
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  // valid stays high after a transaction; the next call decides whether it drops
  task automatic send_item(input logic func, input logic [15:0] tl, input logic [15:0] tr);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.func         <= func;
    cmd_if.target_left  <= tl;
    cmd_if.target_right <= tr;
    do @(posedge clk); while (!(cmd_if.valid && cmd_if.ready));
    items++;
    if (func == FUNC_LOAD) loads++;
    else ticks++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) begin
      if (items < ITEM_GOAL) send_item(FUNC_TICK, 16'($urandom), 16'($urandom));
    end
  endtask

  // hold the sender until every outstanding result has been taken
  task automatic settle();
    cmd_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_config(input logic [15:0] normal, input logic [15:0] slow,
                              input logic [15:0] ramp);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_NORMAL_PERIOD;
    cfg_data <= normal;
    @(posedge clk);
    cfg_idx  <= REG_SLOW_PERIOD;
    cfg_data <= slow;
    @(posedge clk);
    cfg_idx  <= REG_RAMP_STEPS;
    cfg_data <= ramp;
    @(posedge clk);
    cfg_we   <= 1'b0;
    settings++;
  endtask

  function automatic logic [15:0] pick_period();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(200, 6000));
    endcase
  endfunction

  function automatic logic [15:0] pick_ramp();
    case ($urandom_range(0, 6))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd1023;
      3: return 16'($urandom_range(0, 1023));
      default: return 16'($urandom_range(2, 25));
    endcase
  endfunction

  task automatic run_move();
    int kind, span, ml, mr, n_ticks;
    logic signed [15:0] tl, tr;
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      // full-range counts, replaced by the next load after a few ticks
      tl = 16'($urandom);
      tr = 16'($urandom);
      n_ticks = $urandom_range(0, 4);
    end else begin
      span = (kind < 7) ? 40 : 300;
      tl = 16'($urandom_range(0, 2 * span) - span);
      tr = 16'($urandom_range(0, 2 * span) - span);
      if ($urandom_range(0, 15) == 0) begin
        tl = '0;
        tr = '0;
      end
      ml = (tl < 0) ? -int'(tl) : int'(tl);
      mr = (tr < 0) ? -int'(tr) : int'(tr);
      if (mr > ml) ml = mr;
      n_ticks = ml + $urandom_range(0, 2);
      if ($urandom_range(0, 7) == 0) n_ticks = $urandom_range(0, ml);
    end
    if (items < ITEM_GOAL) send_item(FUNC_LOAD, tl, tr);
    send_ticks(n_ticks);
  endtask

  // result side: random stall per transaction
  initial begin
    int stall;
    res_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = idle_draw();
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!(res_if.valid && res_if.ready));
      results_taken++;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("tb_dual_axis_stepper_move_generator: errors");
        $finish;
      end
    end
  end

  initial begin
    rst_n               <= 1'b0;
    cmd_if.valid        <= 1'b0;
    cmd_if.func         <= FUNC_TICK;
    cmd_if.target_left  <= '0;
    cmd_if.target_right <= '0;
    cfg_we              <= 1'b0;
    cfg_idx             <= REG_NORMAL_PERIOD;
    cfg_data            <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle tick, zero moves, direction-only load, short move,
    // full-scale counts, reload mid-move, tick after completion
    send_item(FUNC_TICK, 16'h7FFF, 16'h8000);
    send_item(FUNC_LOAD, 16'sd0, 16'sd0);
    send_item(FUNC_LOAD, -16'sd3, 16'sd2);
    send_item(FUNC_LOAD, 16'sd0, 16'sd0);
    send_item(FUNC_LOAD, 16'sd3, -16'sd5);
    send_ticks(5);
    send_item(FUNC_LOAD, 16'h8000, 16'h7FFF);
    send_ticks(1);
    send_item(FUNC_LOAD, 16'h7FFF, 16'h8000);
    send_ticks(2);
    send_item(FUNC_LOAD, 16'sd1, -16'sd1);
    send_ticks(2);

    // no ramp, extreme periods
    settle();
    write_config(16'hFFFF, 16'h0000, 16'd0);
    send_item(FUNC_LOAD, 16'sd2, -16'sd2);
    send_ticks(2);
    // one-tick ramp, reversed extremes
    settle();
    write_config(16'h0000, 16'hFFFF, 16'd1);
    send_item(FUNC_LOAD, -16'sd3, 16'sd3);
    send_ticks(3);

    while (items < ITEM_GOAL) begin
      settle();
      write_config(pick_period(), pick_period(), pick_ramp());
      steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 6)) begin
        if (items < ITEM_GOAL) run_move();
      end
    end

    settle();
    repeat (DRAIN) @(posedge clk);
    $display("ran %0d loads and %0d ticks under %0d register settings", loads, ticks, settings);
    $display("%0d result transactions taken, %0d left outstanding", results_taken, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_dual_axis_stepper_move_generator: clean");
    end else begin
      $display("tb_dual_axis_stepper_move_generator: errors");
    end
    $finish;
  end

endmodule

@@ dual_axis_stepper_move_generator.f @@
design/dsmg_pkg.sv
design/dsmg_cmd_if.sv
design/dsmg_res_if.sv
design/dual_axis_stepper_move_generator.sv
tb/sv/dsmg_step_checker.sv
tb/sv/tb_dual_axis_stepper_move_generator.sv
